// File: design/fbs_pkg.sv
// Shared types and constants for the frame barrier server.
// No dependencies; every other design file but fbs_ram imports this package.
package fbs_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_SERVER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_LIMIT  = 1'd1;

    localparam logic [15:0] DROP_LIMIT_RST = 16'd5000;

    typedef enum logic [1:0] {
        OP_REPORT  = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] client_id;
        logic [31:0] reported_frame;
    } t_in_req;

    typedef struct packed {
        logic [31:0] sync_frame_out;
        logic        retransmit_request;
    } t_out_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } t_ctl_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic tick;
        logic clear_all;
        logic write_slot;
        logic scan_step;
        logic emit;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       id_ok;
        logic       scan_done;
        logic       ready;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: design/fbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fbs_ctrl.sv
// Sequencing state machine of the frame barrier server.
// Depends on fbs_pkg; drives the datapath through t_ctl_cmd.
module fbs_ctrl import fbs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_sts.op)
                    OP_REPORT:  n_state = i_sts.id_ok ? ST_SCAN : ST_IDLE;
                    OP_TIMEOUT: n_state = ST_EMIT;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = i_sts.ready ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                case (i_sts.op)
                    OP_REPORT:  o_cmd.write_slot = i_sts.id_ok;
                    OP_TIMEOUT: o_cmd.clear_all  = 1'b1;
                    OP_TICK:    o_cmd.tick       = 1'b1;
                    default:    o_cmd            = '0;
                endcase
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: design/fbs_dp.sv
// Datapath of the frame barrier server: client table, counters, scan, output register.
// Depends on fbs_pkg and fbs_ram.
module fbs_dp import fbs_pkg::*; #(
    parameter int unsigned MAX_CLIENTS = 16,
    parameter int unsigned FRAME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in_req               i_in_req,
    input  t_ctl_cmd              i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_rsp              o_out_rsp
);

    localparam int unsigned IW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_CLIENTS + 1);

    logic [1:0]             r_op;
    logic [15:0]            r_id;
    logic [31:0]            r_frame;
    logic                   r_skip;
    logic [15:0]            r_drop_limit;
    logic [MAX_CLIENTS-1:0] r_active;
    logic [FRAME_BITS-1:0]  r_sync;
    logic [CW-1:0]          r_seen;
    logic [31:0]            r_elapsed;
    logic [CW-1:0]          r_scan_idx;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_ready;
    logic                   r_out_vld;
    t_out_rsp               r_out;

    logic [IW-1:0]         slot;
    logic [CW-1:0]         slot_plus1;
    logic                  id_ok;
    logic                  scan_issue;
    logic                  lag;
    logic                  over_limit;
    logic                  advance;
    logic                  out_free;
    logic [FRAME_BITS-1:0] wr_frame;
    logic [FRAME_BITS-1:0] rd_frame;

    assign slot       = r_id[IW-1:0];
    assign slot_plus1 = CW'(slot) + CW'(1);
    assign id_ok      = r_id < 16'(MAX_CLIENTS);
    assign scan_issue = r_scan_idx < r_seen;
    assign lag        = r_cmp_vld && r_active[r_cmp_idx] && (rd_frame != r_sync);
    assign over_limit = r_elapsed > 32'(r_drop_limit);
    // Hold the frame when only the server's own client was ever seen
    assign advance    = !(r_skip && (r_seen == CW'(1)));
    assign out_free   = !r_out_vld || !i_out_stall;
    // A newly joined client starts at the current sync frame
    assign wr_frame   = r_active[slot] ? FRAME_BITS'(r_frame) : r_sync;

    fbs_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (MAX_CLIENTS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_slot),
        .i_waddr (slot),
        .i_wdata (wr_frame),
        .i_raddr (r_scan_idx[IW-1:0]),
        .o_rdata (rd_frame)
    );

    // Item and configuration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_req.operation;
            r_id    <= i_in_req.client_id;
            r_frame <= i_in_req.reported_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip       <= 1'b0;
            r_drop_limit <= DROP_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SKIP_SERVER: r_skip       <= i_cfg_wdata[0];
                CFG_DROP_LIMIT:  r_drop_limit <= i_cfg_wdata;
                default:         r_skip       <= r_skip;
            endcase
        end
    end

    // Active flags: set on join, drop laggers past the limit, clear all on timeout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.clear_all) begin
            r_active <= '0;
        end else begin
            if (i_cmd.write_slot) r_active[slot] <= 1'b1;
            if (lag && over_limit) r_active[r_cmp_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= CW'(1);
        end else if (i_cmd.write_slot && (slot_plus1 > r_seen)) begin
            r_seen <= slot_plus1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= FRAME_BITS'(1);
            r_elapsed <= '0;
        end else if (i_cmd.emit && (r_op == OP_REPORT) && advance) begin
            r_sync    <= r_sync + FRAME_BITS'(1);
            r_elapsed <= '0;
        end else if (i_cmd.tick && (r_elapsed != '1)) begin
            r_elapsed <= r_elapsed + 32'd1;
        end
    end

    // Table scan: one read issued per cycle, compared in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_idx  <= '0;
            r_ready    <= 1'b0;
        end else if (i_cmd.write_slot) begin
            r_scan_idx <= r_skip ? CW'(1) : CW'(0);
            r_cmp_vld  <= 1'b0;
            r_ready    <= 1'b1;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= scan_issue;
            if (scan_issue) begin
                r_cmp_idx  <= r_scan_idx[IW-1:0];
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (lag) r_ready <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.sync_frame_out     <= 32'(r_sync);
            r_out.retransmit_request <= (r_op == OP_TIMEOUT);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.id_ok     = id_ok;
    assign o_sts.scan_done = !scan_issue && !r_cmp_vld;
    assign o_sts.ready     = r_ready;
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_vld;
    assign o_out_rsp       = r_out;

    a_sync_moves_on_release: assert property (@(posedge i_clk)
        $past(i_rst_n) && i_rst_n && !$stable(r_sync)
            |-> $past(i_cmd.emit) && ($past(r_op) == OP_REPORT))
        else $error("sync frame changed without a release");

    a_cmp_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_cmp_vld |-> $past(i_cmd.scan_step))
        else $error("compare stage valid outside a scan");

endmodule

// File: design/frame_barrier_server_top.sv
// Top level of the frame barrier server: controller, datapath and client frame RAM.
// Depends on fbs_pkg, fbs_ctrl, fbs_dp and fbs_ram.
//
// Frame barrier server. Each request carries an operation: a client frame report,
// a receive timeout or a single time tick. A report from an inactive client makes
// it active at the current sync frame; from an active client it records the
// reported frame. The client table is then scanned one slot per cycle through
// the frame RAM's single read port: active clients not at the sync frame hold
// the release, and are dropped once more than drop_limit ticks have passed since
// the last advance. With nothing holding, one response carries the sync frame
// (retransmit_request low) and the frame advances, unless slot 0 is skipped and
// only that slot was ever seen. A timeout clears every active flag and gives a
// response with retransmit_request high. Reports for ids at or beyond
// MAX_CLIENTS, ticks and the unused operation code give no response. Each
// request is decoded first; a valid report then scans the seen slots (less the
// skipped slot 0) and goes on to emit only when nothing holds, and a timeout
// goes from decode straight to emit. A new request is taken while a finished
// response still waits in the output register; a second response waits until
// that one is taken. Write configuration only while the block is idle.
module frame_barrier_server_top import fbs_pkg::*; #(
    parameter int unsigned MAX_CLIENTS = 16,
    parameter int unsigned FRAME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_rsp              o_out_rsp
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    // Sequencer: decode the request, run the scan, release the response
    fbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Client table, sync frame, tick counter and output register
    fbs_dp #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_req    (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // An accepted request always makes the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted without leaving idle");

    // Never overwrite a response that is still held by the receiver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("response loaded over a stalled response");

endmodule
